### sv/tws_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Trie word store package
// Sizes, command codes and the control and status bundles shared by the
// controller, the datapath and the top level.
// ----------------------------------------------------------------------------
package tws_pkg;

   localparam int NODE_COUNT    = 1024;
   localparam int ALPHABET_SIZE = 26;
   localparam int NODE_BITS     = $clog2(NODE_COUNT);
   localparam int FREE_BITS     = NODE_BITS + 1;
   localparam int CMD_BITS      = 2;
   localparam int LETTER_BITS   = 5;

   localparam logic [CMD_BITS-1:0] CMD_INSERT = 2'd0;
   localparam logic [CMD_BITS-1:0] CMD_SEARCH = 2'd1;
   localparam logic [CMD_BITS-1:0] CMD_PREFIX = 2'd2;
   localparam logic [CMD_BITS-1:0] CMD_UNUSED = 2'd3;

   typedef logic [NODE_BITS-1:0] node_type;
   typedef logic [FREE_BITS-1:0] free_type;
   typedef node_type [ALPHABET_SIZE-1:0] row_type;

   typedef struct packed {
      logic init;
      logic capture;
      logic walk;
      logic alloc;
      logic finish;
   } ctrl_cmd_type;

   typedef struct packed {
      logic in_walk;
      logic in_last;
      logic item_last;
      logic need_alloc;
      logic out_free;
   } dp_stat_type;

endpackage

### sv/tws_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Trie word store controller
// Sequences each request through row fetch, walk, node allocation and the
// end-of-word check, and drives the datapath through a command bundle.
// ----------------------------------------------------------------------------
module tws_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  tws_pkg::dp_stat_type  stat,
   output tws_pkg::ctrl_cmd_type cmd
);

   localparam logic [2:0] ST_INIT  = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_WALK  = 3'd2;
   localparam logic [2:0] ST_ALLOC = 3'd3;
   localparam logic [2:0] ST_CHECK = 3'd4;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_INIT: begin
            // The root is the only node that must be clean before the first word.
            cmd.init = 1'b1;
            state_in = ST_IDLE;
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               if (stat.in_walk) begin
                  state_in = ST_WALK;
               end else if (stat.in_last) begin
                  state_in = ST_CHECK;
               end
            end
         end
         ST_WALK: begin
            cmd.walk = 1'b1;
            if (stat.need_alloc) begin
               state_in = ST_ALLOC;
            end else if (stat.item_last) begin
               state_in = ST_CHECK;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_ALLOC: begin
            cmd.alloc = 1'b1;
            state_in  = stat.item_last ? ST_CHECK : ST_IDLE;
         end
         ST_CHECK: begin
            // Wait here until the result register can take the answer.
            if (stat.out_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_INIT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### sv/tws_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Trie word store datapath
// Holds the node rows, the word-end bits, the walk cursor, the free-node
// counter and the result register.
// ----------------------------------------------------------------------------
module tws_datapath (
   input  logic                                   clock,
   input  logic                                   reset,
   input  tws_pkg::ctrl_cmd_type                  cmd,
   output tws_pkg::dp_stat_type                   stat,
   input  logic [tws_pkg::CMD_BITS-1:0]           req_command,
   input  logic [tws_pkg::LETTER_BITS-1:0]        req_letter,
   input  logic                                   req_has_letter,
   input  logic                                   req_last,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic [tws_pkg::CMD_BITS-1:0]           rsp_op_done,
   output logic                                   rsp_found,
   output logic                                   rsp_pool_full
);

   // Each row holds the child links of one node. A node's row and word-end
   // bit are cleared when the node is handed out, so no sweep is needed.
   tws_pkg::row_type row_mem [tws_pkg::NODE_COUNT];
   logic             wend_mem [tws_pkg::NODE_COUNT];

   logic [tws_pkg::CMD_BITS-1:0]    item_cmd_ff;
   logic [tws_pkg::LETTER_BITS-1:0] item_letter_ff;
   logic                            item_last_ff;

   tws_pkg::node_type cursor_ff;
   tws_pkg::node_type cursor_in;
   logic              missed_ff;
   logic              missed_in;
   logic              full_ff;
   logic              full_in;
   tws_pkg::free_type next_free_ff;
   tws_pkg::free_type next_free_in;

   tws_pkg::row_type row_q_ff;
   logic             wend_q_ff;

   logic                         rsp_valid_ff;
   logic [tws_pkg::CMD_BITS-1:0] rsp_op_done_ff;
   logic                         rsp_found_ff;
   logic                         rsp_pool_full_ff;

   logic              letter_ok;
   tws_pkg::node_type child;
   tws_pkg::node_type new_node;
   tws_pkg::row_type  row_upd;
   logic              hit;
   logic              pool_empty;
   logic              need_alloc;
   logic              row_we;
   tws_pkg::row_type  row_wdata;
   logic              wend_we;
   logic              found_res;
   logic              full_res;

   assign letter_ok  = int'(item_letter_ff) < tws_pkg::ALPHABET_SIZE;
   assign new_node   = next_free_ff[tws_pkg::NODE_BITS-1:0];
   assign pool_empty = next_free_ff == tws_pkg::FREE_BITS'(tws_pkg::NODE_COUNT);

   always_comb begin
      child   = '0;
      row_upd = row_q_ff;
      for (int i = 0; i < tws_pkg::ALPHABET_SIZE; i++) begin
         if (int'(item_letter_ff) == i) begin
            child      = row_q_ff[i];
            row_upd[i] = new_node;
         end
      end
   end

   assign hit        = child != '0;
   assign need_alloc = !missed_ff && letter_ok && !hit &&
                       (item_cmd_ff == tws_pkg::CMD_INSERT) && !pool_empty;

   always_comb begin
      cursor_in    = cursor_ff;
      missed_in    = missed_ff;
      full_in      = full_ff;
      next_free_in = next_free_ff;
      if (cmd.walk && !missed_ff) begin
         if (!letter_ok) begin
            missed_in = 1'b1;
         end else if (hit) begin
            cursor_in = child;
         end else if (item_cmd_ff != tws_pkg::CMD_INSERT) begin
            missed_in = 1'b1;
         end else if (pool_empty) begin
            missed_in = 1'b1;
            full_in   = 1'b1;
         end else begin
            cursor_in    = new_node;
            next_free_in = next_free_ff + tws_pkg::FREE_BITS'(1);
         end
      end
      if (cmd.finish) begin
         cursor_in = '0;
         missed_in = 1'b0;
         full_in   = 1'b0;
      end
   end

   // The parent row is written back with the new link during the walk; the
   // new node's own row is cleared in the following cycle.
   assign row_we    = (cmd.walk && need_alloc) || cmd.alloc || cmd.init;
   assign row_wdata = cmd.walk ? row_upd : '0;
   assign wend_we   = cmd.init || cmd.alloc ||
                      (cmd.finish && (item_cmd_ff == tws_pkg::CMD_INSERT) && !missed_ff);

   always_ff @(posedge clock) begin
      if (row_we) begin
         row_mem[cursor_ff] <= row_wdata;
      end
      if (cmd.capture) begin
         row_q_ff <= row_mem[cursor_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (wend_we) begin
         wend_mem[cursor_ff] <= cmd.finish;
      end
      wend_q_ff <= wend_mem[cursor_in];
   end

   always_comb begin
      unique case (item_cmd_ff)
         tws_pkg::CMD_INSERT: found_res = !missed_ff;
         tws_pkg::CMD_SEARCH: found_res = !missed_ff && wend_q_ff;
         tws_pkg::CMD_PREFIX: found_res = !missed_ff;
         default:             found_res = 1'b0;
      endcase
   end

   assign full_res = (item_cmd_ff == tws_pkg::CMD_INSERT) && full_ff;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         item_cmd_ff    <= req_command;
         item_letter_ff <= req_letter;
         item_last_ff   <= req_last;
      end
      if (cmd.finish) begin
         rsp_op_done_ff   <= item_cmd_ff;
         rsp_found_ff     <= found_res;
         rsp_pool_full_ff <= full_res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cursor_ff    <= '0;
         missed_ff    <= 1'b0;
         full_ff      <= 1'b0;
         next_free_ff <= tws_pkg::FREE_BITS'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         cursor_ff    <= cursor_in;
         missed_ff    <= missed_in;
         full_ff      <= full_in;
         next_free_ff <= next_free_in;
         if (cmd.finish) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign stat.in_walk    = req_has_letter && (req_command != tws_pkg::CMD_UNUSED);
   assign stat.in_last    = req_last && (req_command != tws_pkg::CMD_UNUSED);
   assign stat.item_last  = item_last_ff;
   assign stat.need_alloc = need_alloc;
   assign stat.out_free   = !rsp_valid_ff || rsp_ready;

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_op_done   = rsp_op_done_ff;
   assign rsp_found     = rsp_found_ff;
   assign rsp_pool_full = rsp_pool_full_ff;

endmodule

### sv/trie_word_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Trie word store
// A 26-way prefix tree in a fixed node pool with insert, search and prefix
// commands fed one letter per request.
// ----------------------------------------------------------------------------
// Usage:
// Words enter on the req_ channel one letter per request; req_last marks the
// final request of a word and a request without a letter stands for the
// empty word. Only the final request of a word produces a response on the
// rsp_ channel: the command it finished, found, and pool_full for an insert
// that ran out of nodes. Requests with the unused command code are taken
// and dropped.
// Timing: each letter takes a row read and a walk step, plus an allocation
// step when an insert hands out a new node, since that node's row is
// cleared in its own write cycle. The end-of-word check follows the last
// letter's steps and waits while the output register still holds a response.
// Requests are taken only in the idle state, so a new letter waits until
// the one before is through. The rate is set by the single-ported node-row
// memory: each child link read gives the next row address. After reset
// the controller clears the root; other nodes are cleared as they are
// allocated, so there is no sweep. The response sits in an output register;
// while it waits, new requests are still accepted; only the check holds off.
module trie_word_store (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [tws_pkg::CMD_BITS-1:0]      req_command,
   input  logic [tws_pkg::LETTER_BITS-1:0]   req_letter,
   input  logic                              req_has_letter,
   input  logic                              req_last,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [tws_pkg::CMD_BITS-1:0]      rsp_op_done,
   output logic                              rsp_found,
   output logic                              rsp_pool_full
);

   tws_pkg::ctrl_cmd_type ctrl_cmd;
   tws_pkg::dp_stat_type  dp_stat;

   tws_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (dp_stat),
      .cmd       (ctrl_cmd)
   );

   tws_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (ctrl_cmd),
      .stat           (dp_stat),
      .req_command    (req_command),
      .req_letter     (req_letter),
      .req_has_letter (req_has_letter),
      .req_last       (req_last),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_op_done    (rsp_op_done),
      .rsp_found      (rsp_found),
      .rsp_pool_full  (rsp_pool_full)
   );

`ifndef SYNTHESIS
   a_finish_shows_result : assert property (@(posedge clock) disable iff (reset)
      ctrl_cmd.finish |=> rsp_valid)
      else $error("Finished word did not present a response.");

   a_no_overwrite : assert property (@(posedge clock) disable iff (reset)
      ctrl_cmd.finish |-> dp_stat.out_free)
      else $error("Response loaded over one not yet taken.");

   a_single_step : assert property (@(posedge clock) disable iff (reset)
      $onehot0({ctrl_cmd.init, ctrl_cmd.walk, ctrl_cmd.alloc, ctrl_cmd.finish}))
      else $error("More than one datapath step commanded in a cycle.");

   a_dropped_request_idle : assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready &&
       (req_command == tws_pkg::CMD_UNUSED || (!req_has_letter && !req_last)))
      |=> req_ready)
      else $error("Request with no effect did not return to idle.");
`endif

endmodule
